/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks on the motor drive block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define MDRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property that is also evaluated during reset.
`define MDRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mdrb_pkg.sv */
// ----------------------------------------------------------------------------
// mdrb_pkg
// Types and constants of the motor drive ramp and brake controller.
// ----------------------------------------------------------------------------
package mdrb_pkg;

  localparam int unsigned StickW = 9;
  localparam int unsigned LevelW = 8;
  localparam int unsigned TickW  = 5;
  localparam int unsigned ProdW  = StickW + LevelW;

  localparam logic [TickW-1:0] BRAKE_TICKS   = 5'd10;
  localparam logic [TickW-1:0] ROLLOUT_TICKS = 5'd20;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DRIVE = 2'd1,
    MODE_BRAKE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_POWER = 2'd1,
    CMD_COAST = 2'd2,
    CMD_BRAKE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_FWD_MAX_POWER  = 3'd0,
    REG_FWD_RAMP_START = 3'd1,
    REG_FWD_RAMP_STEP  = 3'd2,
    REG_REV_MAX_POWER  = 3'd3,
    REG_REV_RAMP_START = 3'd4,
    REG_REV_RAMP_STEP  = 3'd5,
    REG_BRAKE_LVL_FWD  = 3'd6,
    REG_BRAKE_LVL_REV  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] fwd_max_power;
    logic [LevelW-1:0] fwd_ramp_start;
    logic [LevelW-1:0] fwd_ramp_step;
    logic [LevelW-1:0] rev_max_power;
    logic [LevelW-1:0] rev_ramp_start;
    logic [LevelW-1:0] rev_ramp_step;
    logic [LevelW-1:0] brake_level_fwd;
    logic [LevelW-1:0] brake_level_rev;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [LevelW-1:0] level;
    logic              rev;
  } res_t;

  // Power after scaling: floor(prod / 255), saturated to 255.
  // floor(x / 255) = (x + (x >> 8) + 1) >> 8 holds for all x up to 255 * 256.
  function automatic logic [LevelW-1:0] div255_sat(input logic [ProdW-1:0] prod);
    logic [ProdW:0]   sum;
    logic [ProdW-8:0] quo;
    sum = {1'b0, prod} + {9'd0, prod[ProdW-1:8]} + {{ProdW{1'b0}}, 1'b1};
    quo = sum[ProdW:8];
    div255_sat = (quo[ProdW-8:LevelW] != '0) ? {LevelW{1'b1}} : quo[LevelW-1:0];
  endfunction

endpackage

/* rtl/mdrb_scale.sv */
// ----------------------------------------------------------------------------
// mdrb_scale
// Stick magnitude times the maximum power of the stick's direction.
// ----------------------------------------------------------------------------
module mdrb_scale import mdrb_pkg::*; (
  input  logic [StickW-1:0] stick_i,
  input  cfg_t              cfg_i,
  output logic [ProdW-1:0]  prod_o
);

  logic [StickW-1:0] mag;
  logic [LevelW-1:0] max_pwr;

  // A stick of -256 gives a magnitude of 256, which still fits in nine bits.
  assign mag     = stick_i[StickW-1] ? (~stick_i + 9'd1) : stick_i;
  assign max_pwr = stick_i[StickW-1] ? cfg_i.rev_max_power : cfg_i.fwd_max_power;
  assign prod_o  = {{LevelW{1'b0}}, mag} * {{StickW{1'b0}}, max_pwr};

endmodule

/* rtl/mdrb_ctrl.sv */
// ----------------------------------------------------------------------------
// mdrb_ctrl
// Idle, drive and brake state machine with ramp, rollout and brake timing.
// ----------------------------------------------------------------------------
module mdrb_ctrl import mdrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [StickW-1:0] stick_i,
  input  logic [ProdW-1:0]  prod_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  mode_e             mode_q, mode_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [StickW-1:0] prev_q, prev_d;
  logic [LevelW-1:0] power_q, power_d;

  logic              jz, jpos, jneg, ppos, pneg, reversal;
  logic [LevelW-1:0] norm, start, step, ramp_pwr, drive_pwr;
  logic [LevelW:0]   ramp_sum;
  logic [TickW-1:0]  tick_inc;

  assign jz       = (stick_i == '0);
  assign jneg     = stick_i[StickW-1];
  assign jpos     = !jneg && !jz;
  assign pneg     = prev_q[StickW-1];
  assign ppos     = !pneg && (prev_q != '0);
  assign reversal = (jpos && pneg) || (jneg && ppos);

  assign norm     = div255_sat(prod_i);
  assign start    = jneg ? cfg_i.rev_ramp_start : cfg_i.fwd_ramp_start;
  assign step     = jneg ? cfg_i.rev_ramp_step  : cfg_i.fwd_ramp_step;
  assign ramp_sum = {1'b0, power_q} + {1'b0, step};
  assign ramp_pwr = ramp_sum[LevelW] ? {LevelW{1'b1}} : ramp_sum[LevelW-1:0];
  assign drive_pwr = (norm > start && norm > power_q) ? ramp_pwr : norm;
  assign tick_inc = tick_q + 5'd1;

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    tick_d  = tick_q;
    prev_d  = prev_q;
    power_d = power_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (!jz) begin
          mode_d = MODE_DRIVE;
        end
      end
      MODE_DRIVE: begin
        if (reversal) begin
          tick_d  = '0;
          power_d = '0;
          mode_d  = MODE_BRAKE;
        end else if (!jz) begin
          power_d = drive_pwr;
          prev_d  = stick_i;
          tick_d  = '0;
        end else if (tick_q < ROLLOUT_TICKS) begin
          power_d = '0;
          tick_d  = tick_inc;
        end else begin
          prev_d  = '0;
          power_d = '0;
          mode_d  = MODE_IDLE;
        end
      end
      MODE_BRAKE: begin
        if (tick_q < BRAKE_TICKS) begin
          tick_d = tick_inc;
        end else if (jz) begin
          tick_d = '0;
          prev_d = '0;
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  // Result of the current tick.
  always_comb begin
    res_o = '{cmd: CMD_HOLD, level: '0, rev: 1'b0};
    unique case (mode_q)
      MODE_DRIVE: begin
        if (!reversal && !jz) begin
          res_o.cmd   = CMD_POWER;
          res_o.level = drive_pwr;
          res_o.rev   = jneg;
        end else if (!reversal && tick_q < ROLLOUT_TICKS) begin
          res_o.cmd = CMD_COAST;
        end
      end
      MODE_BRAKE: begin
        if (tick_q < BRAKE_TICKS) begin
          res_o.cmd   = CMD_BRAKE;
          res_o.level = pneg ? cfg_i.brake_level_rev : cfg_i.brake_level_fwd;
        end
      end
      default: begin
        res_o.cmd = CMD_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      tick_q  <= '0;
      prev_q  <= '0;
      power_q <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      prev_q  <= prev_d;
      power_q <= power_d;
    end
  end

endmodule

/* rtl/motor_drive_ramp_brake_fsm.sv */
// ----------------------------------------------------------------------------
// motor_drive_ramp_brake_fsm
// H-bridge controller: one joystick word in, one bridge command word out.
// ----------------------------------------------------------------------------
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    stick_position_i
// out       out_valid_o / out_ready_i  bridge_command_o, bridge_level_o, reverse_dir_o
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each word passes an input register and a result register, one word per cycle
// sustained while the result is read. The multiply by the maximum power sits
// before the input register; the state machine update sits before the result
// register. A stalled result holds the result register and a full input
// register; cfg writes are always taken. Reset restores default tuning, idle.
// ----------------------------------------------------------------------------
module motor_drive_ramp_brake_fsm import mdrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [StickW-1:0] stick_position_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        bridge_command_o,
  output logic [LevelW-1:0] bridge_level_o,
  output logic              reverse_dir_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [LevelW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              s1_valid_q, out_valid_q;
  logic [StickW-1:0] s1_stick_q;
  logic [ProdW-1:0]  s1_prod_q, prod;
  res_t              res, res_q;
  logic              advance, fire, in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fwd_max_power: 8'd70, fwd_ramp_start: 8'd30, fwd_ramp_step: 8'd5,
                 rev_max_power: 8'd60, rev_ramp_start: 8'd30, rev_ramp_step: 8'd5,
                 brake_level_fwd: 8'd200, brake_level_rev: 8'd200};
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FWD_MAX_POWER:  cfg_q.fwd_max_power   <= cfg_data_i;
        REG_FWD_RAMP_START: cfg_q.fwd_ramp_start  <= cfg_data_i;
        REG_FWD_RAMP_STEP:  cfg_q.fwd_ramp_step   <= cfg_data_i;
        REG_REV_MAX_POWER:  cfg_q.rev_max_power   <= cfg_data_i;
        REG_REV_RAMP_START: cfg_q.rev_ramp_start  <= cfg_data_i;
        REG_REV_RAMP_STEP:  cfg_q.rev_ramp_step   <= cfg_data_i;
        REG_BRAKE_LVL_FWD:  cfg_q.brake_level_fwd <= cfg_data_i;
        REG_BRAKE_LVL_REV:  cfg_q.brake_level_rev <= cfg_data_i;
        default:            cfg_q                 <= cfg_q;
      endcase
    end
  end

  // The whole pipe moves whenever the result register is free or being read.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  mdrb_scale u_scale (
    .stick_i (stick_position_i),
    .cfg_i   (cfg_q),
    .prod_o  (prod)
  );

  mdrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .stick_i (s1_stick_q),
    .prod_i  (s1_prod_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_stick_q <= stick_position_i;
      s1_prod_q  <= prod;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bridge_command_o = res_q.cmd;
  assign bridge_level_o   = res_q.level;
  assign reverse_dir_o    = res_q.rev;

endmodule

/* rtl/mdrb_checker.sv */
// ----------------------------------------------------------------------------
// mdrb_checker
// Port-level checks on the motor drive controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdrb_checker import mdrb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        bridge_command_o,
  input logic [LevelW-1:0] bridge_level_o,
  input logic              reverse_dir_o
);

  logic idle_cmd;

  assign idle_cmd = (bridge_command_o == CMD_HOLD) || (bridge_command_o == CMD_COAST);

  `MDRB_ASSERT_ALWAYS(a_rst_no_out, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")
  `MDRB_ASSERT(a_stall_hold, clk_i, rst_ni,
               out_valid_o && !out_ready_i |=> out_valid_o && $stable(bridge_command_o)
               && $stable(bridge_level_o), "stalled word changed")
  `MDRB_ASSERT(a_empty_ready, clk_i, rst_ni, !out_valid_o |-> in_ready_o,
               "input stalled with empty output")
  `MDRB_ASSERT(a_quiet_cmd, clk_i, rst_ni,
               out_valid_o && idle_cmd |-> bridge_level_o == '0 && !reverse_dir_o,
               "hold or coast with level or direction")
  `MDRB_ASSERT(a_brake_dir, clk_i, rst_ni,
               out_valid_o && bridge_command_o == CMD_BRAKE |-> !reverse_dir_o,
               "brake with reverse flag")

endmodule

bind motor_drive_ramp_brake_fsm mdrb_checker u_mdrb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .bridge_command_o (bridge_command_o),
  .bridge_level_o   (bridge_level_o),
  .reverse_dir_o    (reverse_dir_o)
);

/* dv/motor_drive_ramp_brake_fsm_tb.sv */
// ----------------------------------------------------------------------------
// motor_drive_ramp_brake_fsm_tb
// Self-checking bench for the H-bridge ramp and brake controller. Stick words
// go in through a queue-fed driver. A cycle-free model of the controller
// predicts one bridge command word per stick word, and the monitor compares
// each result word with it. Several tuning sets are loaded between phases,
// including all-zero and all-ones.
// ----------------------------------------------------------------------------
module motor_drive_ramp_brake_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdrb_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int LongHold   = 60;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b1;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [StickW-1:0] stick_position_i = '0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [1:0]        bridge_command_o;
  logic [LevelW-1:0] bridge_level_o;
  logic              reverse_dir_o;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i      = '0;
  logic [LevelW-1:0] cfg_data_i       = '0;

  motor_drive_ramp_brake_fsm DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stick_position_i (stick_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bridge_command_o (bridge_command_o),
    .bridge_level_o   (bridge_level_o),
    .reverse_dir_o    (reverse_dir_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tuning copy and controller state of the prediction.
  logic [LevelW-1:0] tuning [8];
  mode_e             mode_q     = MODE_IDLE;
  logic [TickW-1:0]  tick_q     = '0;
  int                last_stick = 0;
  logic [LevelW-1:0] power_q    = '0;

  logic [StickW-1:0] stick_backlog [$];
  res_t              pending_commands [$];

  int idle_pct      = 25;
  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int brakes_seen   = 0;
  int coasts_seen   = 0;
  int tuning_sets   = 1;
  int quiet_cycles  = 0;

  function automatic res_t controller_step(input logic [StickW-1:0] word);
    res_t r;
    int   s, mag, norm, maxp, start, step, boosted;
    logic fwd;
    s = int'($signed(word));
    r.cmd   = CMD_HOLD;
    r.level = '0;
    r.rev   = 1'b0;
    case (mode_q)
      MODE_IDLE: begin
        if (s != 0) mode_q = MODE_DRIVE;
      end
      MODE_DRIVE: begin
        if ((s > 0 && last_stick < 0) || (s < 0 && last_stick > 0)) begin
          tick_q  = '0;
          power_q = '0;
          mode_q  = MODE_BRAKE;
        end else if (s != 0) begin
          fwd   = (s > 0);
          maxp  = fwd ? int'(tuning[REG_FWD_MAX_POWER])  : int'(tuning[REG_REV_MAX_POWER]);
          start = fwd ? int'(tuning[REG_FWD_RAMP_START]) : int'(tuning[REG_REV_RAMP_START]);
          step  = fwd ? int'(tuning[REG_FWD_RAMP_STEP])  : int'(tuning[REG_REV_RAMP_STEP]);
          mag   = fwd ? s : -s;
          norm  = mag * maxp / 255;
          if (norm > 255) norm = 255;
          // Below the target and above the ramp start, power rises by the step.
          if (norm > start && norm > int'(power_q)) begin
            boosted = int'(power_q) + step;
            power_q = (boosted > 255) ? 8'd255 : 8'(boosted);
          end else begin
            power_q = 8'(norm);
          end
          r.cmd      = CMD_POWER;
          r.level    = power_q;
          r.rev      = !fwd;
          last_stick = s;
          tick_q     = '0;
        end else if (tick_q < ROLLOUT_TICKS) begin
          r.cmd   = CMD_COAST;
          power_q = '0;
          tick_q  = tick_q + 5'd1;
        end else begin
          last_stick = 0;
          power_q    = '0;
          mode_q     = MODE_IDLE;
        end
      end
      MODE_BRAKE: begin
        if (tick_q < BRAKE_TICKS) begin
          r.cmd   = CMD_BRAKE;
          r.level = (last_stick < 0) ? tuning[REG_BRAKE_LVL_REV] : tuning[REG_BRAKE_LVL_FWD];
          tick_q  = tick_q + 5'd1;
        end else if (s == 0) begin
          tick_q     = '0;
          last_stick = 0;
          mode_q     = MODE_IDLE;
        end
      end
      default: mode_q = MODE_IDLE;
    endcase
    return r;
  endfunction

  // Stick driver: holds a word until accepted, idles in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    logic              fire;
    logic              next_valid;
    logic [StickW-1:0] next_word;
    int                gap_left;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      stick_position_i <= '0;
      gap_left = 0;
    end else begin
      fire       = in_valid_i && in_ready_o;
      next_valid = in_valid_i;
      next_word  = stick_position_i;
      if (fire) begin
        pending_commands.push_back(controller_step(stick_position_i));
        words_sent++;
      end
      if (in_valid_i && !fire) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (stick_backlog.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left   = $urandom_range(0, 8);
        next_valid = 1'b0;
      end else if (stick_backlog.size() > 0) begin
        next_valid = 1'b1;
        next_word  = stick_backlog.pop_front();
      end else begin
        next_valid = 1'b0;
      end
      in_valid_i       <= next_valid;
      stick_position_i <= next_word;
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_cmd;
    logic next_ready;
    int   stall_left;
    int   hold_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_commands.size() == 0) begin
          $error("result word with nothing expected: cmd %0d level %0d rev %0d",
                 bridge_command_o, bridge_level_o, reverse_dir_o);
          errors++;
        end else begin
          exp_cmd = pending_commands.pop_front();
          if (exp_cmd.cmd == CMD_BRAKE) brakes_seen++;
          if (exp_cmd.cmd == CMD_COAST) coasts_seen++;
          if (bridge_command_o !== exp_cmd.cmd) begin
            $error("bridge_command: expected %0d, got %0d", exp_cmd.cmd, bridge_command_o);
            errors++;
          end
          if (bridge_level_o !== exp_cmd.level) begin
            $error("bridge_level: expected %0d, got %0d", exp_cmd.level, bridge_level_o);
            errors++;
          end
          if (reverse_dir_o !== exp_cmd.rev) begin
            $error("reverse_dir: expected %0d, got %0d", exp_cmd.rev, reverse_dir_o);
            errors++;
          end
        end
        // Two long hold-offs so the pipeline fills and backs up the input.
        if (results_seen == 200 || results_seen == 1200) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 8);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready_i <= next_ready;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("no handshake for %0d cycles", QuietLimit);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [LevelW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tuning[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_tuning(input logic [LevelW-1:0] f_max, f_start, f_step,
                             r_max, r_start, r_step, b_fwd, b_rev);
    write_reg(REG_FWD_MAX_POWER,  f_max);
    write_reg(REG_FWD_RAMP_START, f_start);
    write_reg(REG_FWD_RAMP_STEP,  f_step);
    write_reg(REG_REV_MAX_POWER,  r_max);
    write_reg(REG_REV_RAMP_START, r_start);
    write_reg(REG_REV_RAMP_STEP,  r_step);
    write_reg(REG_BRAKE_LVL_FWD,  b_fwd);
    write_reg(REG_BRAKE_LVL_REV,  b_rev);
    tuning_sets++;
  endtask

  task automatic load_random_tuning();
    load_tuning(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Checked at the falling edge so queue and valid are both settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (stick_backlog.size() > 0 || in_valid_i || pending_commands.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly runs of one direction and zero runs long enough for rollout, so
  // ramps, reversals, full brakes and returns to idle all come up often.
  task automatic queue_stick_runs(input int count);
    int left, kind, len, mag, inc, dir, v;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        len = $urandom_range(1, 30);
        dir = $urandom_range(0, 1);
        mag = $urandom_range(1, 80);
        inc = $urandom_range(0, 25);
      end else if (kind <= 5) begin
        len = $urandom_range(1, 26);
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int i = 0; i < len && left > 0; i++) begin
        if (kind <= 3) begin
          if ($urandom_range(0, 3) == 0) mag = $urandom_range(1, 256);
          else mag = mag + inc;
          if (mag > 256) mag = 256;
          if (dir == 0 && mag > 255) mag = 255;
          v = dir ? -mag : mag;
        end else if (kind <= 5) begin
          v = 0;
        end else if (kind == 6) begin
          case ($urandom_range(0, 4))
            0: v = 255;
            1: v = -256;
            2: v = -255;
            3: v = 1;
            default: v = -1;
          endcase
        end else begin
          v = $urandom_range(0, 511);
        end
        stick_backlog.push_back(StickW'(v));
        left--;
      end
    end
  endtask

  initial begin
    int opening [25];
    // Reset goes low shortly after time zero so the flops see a clean edge.
    #1 rst_ni = 1'b0;
    opening = '{0, 255, 255, 100, 0, 255, -256, -256, -256, -256, -256, -256,
                -256, -256, -256, -256, -256, -256, 0, -256, -256, -1, 1, 1, 0};
    tuning[REG_FWD_MAX_POWER]  = 8'd70;
    tuning[REG_FWD_RAMP_START] = 8'd30;
    tuning[REG_FWD_RAMP_STEP]  = 8'd5;
    tuning[REG_REV_MAX_POWER]  = 8'd60;
    tuning[REG_REV_RAMP_START] = 8'd30;
    tuning[REG_REV_RAMP_STEP]  = 8'd5;
    tuning[REG_BRAKE_LVL_FWD]  = 8'd200;
    tuning[REG_BRAKE_LVL_REV]  = 8'd200;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default tuning: idle entry, ramp, coast, reversal into a full brake.
    foreach (opening[i]) stick_backlog.push_back(StickW'(opening[i]));
    queue_stick_runs(400);
    wait_drained();

    load_tuning(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_stick_runs(300);
    wait_drained();

    load_tuning(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    idle_pct = 10;
    queue_stick_runs(250);
    wait_drained();

    load_random_tuning();
    idle_pct = 35;
    queue_stick_runs(400);
    wait_drained();

    // Ramp from zero with a huge step saturates at full power.
    load_tuning(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd0, 8'd128);
    idle_pct = 25;
    queue_stick_runs(250);
    wait_drained();

    load_random_tuning();
    idle_pct = 0;
    queue_stick_runs(300);
    wait_drained();

    $display("%0d stick words under %0d tuning sets, %0d results checked",
             words_sent, tuning_sets, results_seen);
    $display("%0d brake and %0d coast words among them", brakes_seen, coasts_seen);
    if (errors == 0 && pending_commands.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
